[rtl/core/pbnfa_pkg.sv]
// Shared types and constants for the page bitmap next-fit allocator.
// No dependencies; used by the allocator top level.
package pbnfa_pkg;

    // Default geometry
    localparam int MAX_PAGES_DEF  = 8192;
    localparam int PAGE_BYTES_DEF = 4096;

    // Bitmap storage word
    localparam int WORD_W  = 32;
    localparam int WB      = $clog2(WORD_W);

    // Port widths
    localparam int ADDR_W      = 25;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    // Low-memory hole marked used by every init request
    localparam int RSV_LO = 'hA0;
    localparam int RSV_HI = 'h100;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Request kinds
    localparam mode_t MODE_INIT  = 2'd0;
    localparam mode_t MODE_ALLOC = 2'd1;
    localparam mode_t MODE_FREE  = 2'd2;
    localparam mode_t MODE_NOP   = 2'd3;

    // Result status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_OOM   = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

    // Configuration register indexes
    localparam cfg_idx_t REG_MEM_SIZE = 1'd0;
    localparam cfg_idx_t REG_KERN_END = 1'd1;

endpackage

[rtl/core/page_bitmap_next_fit_allocator.sv]
// Page bitmap next-fit allocator top level.
// Depends on pbnfa_pkg and pbnfa_ram (bitmap storage, 32 pages per word).
//
// One request at a time, one result per request. The used map lives in a RAM of
// 32-bit words (MAX_PAGES/32 words, 256 by default), one bit per page. An init
// request rewrites every word, one per cycle. An alloc request scans words
// next-fit from the search pointer to the top of usable memory, then from page 1
// up to the pointer, streaming one word read per cycle. A free request is a
// read-modify-write of one word. The RAM read port sets the scan speed. The map
// contents are undefined after reset; no read happens before the first init
// request, since the usable page count is zero until then. A new request is
// taken while a finished result still waits on the result channel.
module page_bitmap_next_fit_allocator #(
    parameter int MAX_PAGES  = pbnfa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = pbnfa_pkg::PAGE_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  pbnfa_pkg::cfg_idx_t              cfg_index,
    input  logic [pbnfa_pkg::CFG_DATA_W-1:0] cfg_data,
    // Request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pbnfa_pkg::IN_TDATA_W-1:0] s_tdata,   // [31:0] free_address
    input  pbnfa_pkg::mode_t                 s_tuser,   // [1:0] mode
    // Result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pbnfa_pkg::OUT_TDATA_W-1:0] m_tdata,  // [24:0] page_address, rest zero
    output pbnfa_pkg::status_t               m_tuser    // [1:0] status
);

    import pbnfa_pkg::*;

    localparam int PW     = $clog2(MAX_PAGES);
    localparam int CW     = PW + 1;
    localparam int PBW    = $clog2(PAGE_BYTES);
    localparam int NWORDS = MAX_PAGES / WORD_W;
    localparam int WIW    = $clog2(NWORDS);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INIT   = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_AWR    = 3'd4;
    localparam logic [2:0] S_FWR    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // Control state
    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         usable_reg, usable_next;
    logic [CW-1:0]         next_search_reg, next_search_next;
    logic [CFG_DATA_W-1:0] cfg_mem_reg, cfg_mem_next;
    logic [CFG_DATA_W-1:0] cfg_kend_reg, cfg_kend_next;
    logic                  phase_reg, phase_next;
    logic                  issue_done_reg, issue_done_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic                  m_valid_reg, m_valid_next;

    // Datapath state
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic [WIW-1:0]    issue_idx_reg, issue_idx_next;
    logic [WIW-1:0]    last_idx_reg, last_idx_next;
    logic [WIW-1:0]    chk_idx_reg, chk_idx_next;
    logic [WIW-1:0]    sweep_idx_reg, sweep_idx_next;
    logic [PW-1:0]     page_reg, page_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    status_t           res_status_reg, res_status_next;
    logic [ADDR_W-1:0] m_addr_reg, m_addr_next;
    status_t           m_status_reg, m_status_next;

    // Bitmap RAM ports
    logic              ram_wr_en;
    logic [WIW-1:0]    ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [WIW-1:0]    ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;

    // Derived values
    logic                  s_fire;
    logic [CFG_DATA_W-1:0] mem_pages;
    logic [CW-1:0]         usable_c;
    logic [CFG_DATA_W:0]   kend_sum;
    logic [CFG_DATA_W:0]   kend_pages;
    logic [CW-1:0]         kp_c;
    logic [CFG_DATA_W-1:0] fpage;
    logic [WORD_W-1:0]     init_word;
    logic [WORD_W-1:0]     free_bits;
    logic [WB-1:0]         hit_bit;
    logic                  hit;
    logic [CW-1:0]         setup_lo;
    logic [CW-1:0]         setup_hi;
    logic [CW-1:0]         setup_last;

    pbnfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_map_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(OUT_TDATA_W-ADDR_W){1'b0}}, m_addr_reg};
    assign m_tuser   = m_status_reg;

    // Usable page count and rounded-up kernel end page, both clipped
    always_comb begin
        mem_pages  = cfg_mem_reg >> PBW;
        usable_c   = (mem_pages > CFG_DATA_W'(MAX_PAGES)) ? CW'(MAX_PAGES)
                                                          : mem_pages[CW-1:0];
        kend_sum   = {1'b0, cfg_kend_reg} + (CFG_DATA_W+1)'(PAGE_BYTES - 1);
        kend_pages = kend_sum >> PBW;
        kp_c       = (kend_pages > (CFG_DATA_W+1)'(usable_c)) ? usable_c
                                                               : kend_pages[CW-1:0];
    end

    assign fpage = s_tdata >> PBW;

    // Init word: free between kernel end and top, except page 0 and the hole
    always_comb begin
        logic [CW-1:0] p;
        p = '0;
        for (int b = 0; b < WORD_W; b++) begin
            p = CW'({sweep_idx_reg, WB'(b)});
            init_word[b] = !((p >= next_search_reg) && (p < usable_reg) &&
                             (p != '0) &&
                             !((p >= CW'(RSV_LO)) && (p < CW'(RSV_HI))));
        end
    end

    // Free pages of the arriving word inside the search window, lowest first
    always_comb begin
        logic [CW-1:0] p;
        p       = '0;
        hit_bit = '0;
        for (int b = 0; b < WORD_W; b++) begin
            p = CW'({chk_idx_reg, WB'(b)});
            free_bits[b] = !ram_rd_data[b] && (p >= lo_reg) && (p < hi_reg);
        end
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                hit_bit = WB'(b);
            end
        end
        hit = |free_bits;
    end

    // Search window for the current phase
    always_comb begin
        setup_lo   = phase_reg ? CW'(1) : next_search_reg;
        setup_hi   = phase_reg ? next_search_reg : usable_reg;
        setup_last = setup_hi - CW'(1);
    end

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        usable_next      = usable_reg;
        next_search_next = next_search_reg;
        cfg_mem_next     = cfg_mem_reg;
        cfg_kend_next    = cfg_kend_reg;
        phase_next       = phase_reg;
        issue_done_next  = issue_done_reg;
        chk_valid_next   = 1'b0;
        m_valid_next     = m_valid_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        issue_idx_next   = issue_idx_reg;
        last_idx_next    = last_idx_reg;
        chk_idx_next     = chk_idx_reg;
        sweep_idx_next   = sweep_idx_reg;
        page_next        = page_reg;
        word_next        = word_reg;
        res_addr_next    = res_addr_reg;
        res_status_next  = res_status_reg;
        m_addr_next      = m_addr_reg;
        m_status_next    = m_status_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = page_reg[PW-1:WB];
        ram_wr_data      = word_reg;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = issue_idx_reg;

        // Configuration writes
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MEM_SIZE: cfg_mem_next  = cfg_data;
                REG_KERN_END: cfg_kend_next = cfg_data;
                default: ;
            endcase
        end

        // Result register drains independently
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    case (s_tuser)
                        MODE_INIT: begin
                            usable_next      = usable_c;
                            next_search_next = kp_c;
                            sweep_idx_next   = '0;
                            state_next       = S_INIT;
                        end
                        MODE_ALLOC: begin
                            phase_next = 1'b0;
                            state_next = S_SETUP;
                        end
                        MODE_FREE: begin
                            if (fpage < CFG_DATA_W'(usable_reg)) begin
                                page_next   = fpage[PW-1:0];
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = fpage[PW-1:WB];
                                state_next  = S_FWR;
                            end else begin
                                res_status_next = ST_RANGE;
                                state_next      = S_DONE;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                ram_wr_en      = 1'b1;
                ram_wr_addr    = sweep_idx_reg;
                ram_wr_data    = init_word;
                sweep_idx_next = sweep_idx_reg + WIW'(1);
                if (sweep_idx_reg == WIW'(NWORDS - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_SETUP: begin
                if (setup_lo < setup_hi) begin
                    lo_next         = setup_lo;
                    hi_next         = setup_hi;
                    issue_idx_next  = setup_lo[PW-1:WB];
                    last_idx_next   = setup_last[PW-1:WB];
                    issue_done_next = 1'b0;
                    state_next      = S_SEARCH;
                end else if (!phase_reg) begin
                    phase_next = 1'b1;
                end else begin
                    res_status_next = ST_OOM;
                    state_next      = S_DONE;
                end
            end
            S_SEARCH: begin
                // Stream one word read per cycle until the window end
                if (!issue_done_reg) begin
                    ram_rd_en      = 1'b1;
                    ram_rd_addr    = issue_idx_reg;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_idx_reg;
                    if (issue_idx_reg == last_idx_reg) begin
                        issue_done_next = 1'b1;
                    end else begin
                        issue_idx_next = issue_idx_reg + WIW'(1);
                    end
                end
                // Check the word that arrived; drop any read still in flight
                if (chk_valid_reg) begin
                    if (hit) begin
                        page_next      = {chk_idx_reg, hit_bit};
                        word_next      = ram_rd_data | (WORD_W'(1) << hit_bit);
                        chk_valid_next = 1'b0;
                        state_next     = S_AWR;
                    end else if (chk_idx_reg == last_idx_reg) begin
                        chk_valid_next = 1'b0;
                        if (!phase_reg) begin
                            phase_next = 1'b1;
                            state_next = S_SETUP;
                        end else begin
                            res_status_next = ST_OOM;
                            state_next      = S_DONE;
                        end
                    end
                end
            end
            S_AWR: begin
                ram_wr_en        = 1'b1;
                next_search_next = CW'(page_reg) + CW'(1);
                res_addr_next    = ADDR_W'({page_reg, {PBW{1'b0}}});
                state_next       = S_DONE;
            end
            S_FWR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data & ~(WORD_W'(1) << page_reg[WB-1:0]);
                if (CW'(page_reg) < next_search_reg) begin
                    next_search_next = CW'(page_reg);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_addr_next   = res_addr_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            usable_reg      <= '0;
            next_search_reg <= '0;
            cfg_mem_reg     <= '0;
            cfg_kend_reg    <= '0;
            phase_reg       <= 1'b0;
            issue_done_reg  <= 1'b1;
            chk_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            usable_reg      <= usable_next;
            next_search_reg <= next_search_next;
            cfg_mem_reg     <= cfg_mem_next;
            cfg_kend_reg    <= cfg_kend_next;
            phase_reg       <= phase_next;
            issue_done_reg  <= issue_done_next;
            chk_valid_reg   <= chk_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        issue_idx_reg  <= issue_idx_next;
        last_idx_reg   <= last_idx_next;
        chk_idx_reg    <= chk_idx_next;
        sweep_idx_reg  <= sweep_idx_next;
        page_reg       <= page_next;
        word_reg       <= word_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_addr_reg     <= m_addr_next;
        m_status_reg   <= m_status_next;
    end

    // The search pointer never passes the top of usable memory
    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        next_search_reg <= usable_reg)
        else $error("search pointer above usable page count");

    // The map is only written while a request is in progress
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !ram_wr_en)
        else $error("bitmap write while idle");

    // Word checks only happen during a scan
    a_chk_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_valid_reg |-> (state_reg == S_SEARCH))
        else $error("word check outside of a scan");

    // Out-of-memory results carry a zero address
    a_oom_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == ST_OOM)) |-> (m_addr_reg == '0))
        else $error("out-of-memory result with nonzero address");

    // An allocated page is marked used when written back
    a_alloc_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_AWR) |-> ram_wr_data[page_reg[WB-1:0]])
        else $error("allocated page not marked used");

endmodule

[rtl/core/pbnfa_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pbnfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for page_bitmap_next_fit_allocator: directed table, then random phases.
// Depends on pbnfa_pkg and the allocator RTL; expected grants come from a local bitmap predictor.

module tb;
    import pbnfa_pkg::*;

    localparam int          PAGES        = MAX_PAGES_DEF;
    localparam logic [31:0] TOP_BYTES    = 32'(MAX_PAGES_DEF * PAGE_BYTES_DEF);
    localparam int          RAND_ITEMS   = 620;
    localparam int          DRAIN_CYCLES = 300;
    localparam int          LIMIT_CYCLES = 1_000_000;

    // One result of the allocator
    typedef struct packed {
        logic [ADDR_W-1:0] page_addr;
        status_t           status;
    } grant_t;

    // One row of the directed table: a register write or a request
    typedef struct packed {
        bit          is_cfg;
        cfg_idx_t    reg_idx;
        mode_t       mode;
        logic [31:0] data;      // register value or free address
        bit          fixed;     // expected grant typed in below
        grant_t      grant;
    } row_t;

    localparam bit ROW_CFG = 1'b1;
    localparam bit ROW_REQ = 1'b0;
    localparam bit FIXED   = 1'b1;
    localparam bit PRED    = 1'b0;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = REG_MEM_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;    // [31:0] free_address
    mode_t                 s_tuser = MODE_NOP;  // [1:0] mode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // [24:0] page_address, rest zero
    status_t               m_tuser;         // [1:0] status

    page_bitmap_next_fit_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Predictor state: mirrors the allocator after reset
    bit [PAGES-1:0] used_map = '1;
    bit [13:0]      usable_pages = '0;
    bit [13:0]      next_page = '0;
    logic [31:0]    mem_size_q = '0;
    logic [31:0]    kern_end_q = '0;

    grant_t            grant_q[$];       // expected grants, oldest first
    logic [ADDR_W-1:0] alloc_pages[$];   // pages handed out in this phase, free targets
    bit                idle_on = 1'b1;
    int unsigned       errors = 0;
    int unsigned       n_granted = 0;
    int unsigned       n_oom = 0;
    int unsigned       n_range = 0;
    int unsigned       cycles = 0;
    int unsigned       stall_left = 0;
    grant_t            want;

    // Directed table
    localparam int DIR_ROWS = 32;
    row_t dir_tab [DIR_ROWS] = '{
        // before any init nothing is usable
        '{ROW_REQ, REG_MEM_SIZE, MODE_ALLOC, 32'h0000_0000, FIXED, '{25'h0, ST_OOM}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_FREE,  32'h0000_0000, FIXED, '{25'h0, ST_RANGE}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_NOP,   32'hFFFF_FFFF, FIXED, '{25'h0, ST_OK}},
        // memory clipped to the max, kernel end rounds up to page 0x101
        '{ROW_CFG, REG_MEM_SIZE, MODE_NOP,   32'hFFFF_FFFF, PRED,  '{25'h0, ST_OK}},
        '{ROW_CFG, REG_KERN_END, MODE_NOP,   32'h0010_0001, PRED,  '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_INIT,  32'h0000_0000, FIXED, '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_ALLOC, 32'h0000_0000, FIXED, '{25'h0101000, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_ALLOC, 32'h0000_0000, FIXED, '{25'h0102000, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_FREE,  32'h0010_1ABC, FIXED, '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_ALLOC, 32'h0000_0000, FIXED, '{25'h0101000, ST_OK}},
        // page zero freed, then handed out with address zero
        '{ROW_REQ, REG_MEM_SIZE, MODE_FREE,  32'h0000_0FFF, FIXED, '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_ALLOC, 32'h0000_0000, FIXED, '{25'h0, ST_OK}},
        // top page is already free; one past the top is out of range
        '{ROW_REQ, REG_MEM_SIZE, MODE_FREE,  32'h01FF_FFFF, FIXED, '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_FREE,  32'h0200_0000, FIXED, '{25'h0, ST_RANGE}},
        // a page of the reserved hole can be freed and reused
        '{ROW_REQ, REG_MEM_SIZE, MODE_FREE,  32'h000A_0000, FIXED, '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_ALLOC, 32'h0000_0000, FIXED, '{25'h00A0000, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_ALLOC, 32'h0000_0000, PRED,  '{25'h0, ST_OK}},
        // no memory at all
        '{ROW_CFG, REG_MEM_SIZE, MODE_NOP,   32'h0000_0000, PRED,  '{25'h0, ST_OK}},
        '{ROW_CFG, REG_KERN_END, MODE_NOP,   32'h0000_0000, PRED,  '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_INIT,  32'h0000_0000, FIXED, '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_ALLOC, 32'h0000_0000, FIXED, '{25'h0, ST_OOM}},
        // kernel end past memory: nothing freed
        '{ROW_CFG, REG_MEM_SIZE, MODE_NOP,   32'h0010_4FFF, PRED,  '{25'h0, ST_OK}},
        '{ROW_CFG, REG_KERN_END, MODE_NOP,   32'hFFFF_FFFF, PRED,  '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_INIT,  32'h0000_0000, FIXED, '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_ALLOC, 32'h0000_0000, FIXED, '{25'h0, ST_OOM}},
        // two free pages: fill the map, then free one and take it again
        '{ROW_CFG, REG_KERN_END, MODE_NOP,   32'h0010_1001, PRED,  '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_INIT,  32'h0000_0000, FIXED, '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_ALLOC, 32'h0000_0000, PRED,  '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_ALLOC, 32'h0000_0000, PRED,  '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_ALLOC, 32'h0000_0000, FIXED, '{25'h0, ST_OOM}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_FREE,  32'h0010_3000, PRED,  '{25'h0, ST_OK}},
        '{ROW_REQ, REG_MEM_SIZE, MODE_ALLOC, 32'h0000_0000, PRED,  '{25'h0, ST_OK}}
    };

    // Work out the grant for one request and update the predictor state
    function automatic grant_t compute_grant(input mode_t md, input logic [31:0] fa);
        grant_t      g;
        int unsigned kp;
        int unsigned pg;
        bit          hit;
        g.page_addr = '0;
        g.status    = ST_OK;
        hit = 1'b0;
        pg  = 0;
        case (md)
            MODE_INIT: begin
                usable_pages = (mem_size_q > TOP_BYTES) ? 14'(PAGES)
                                                        : 14'(mem_size_q / PAGE_BYTES_DEF);
                kp = 32'((33'(kern_end_q) + PAGE_BYTES_DEF - 1) / PAGE_BYTES_DEF);
                if (kp > usable_pages)
                    kp = usable_pages;
                used_map = '1;
                for (int i = kp; i < usable_pages; i++)
                    used_map[i] = 1'b0;
                used_map[0] = 1'b1;
                for (int i = RSV_LO; i < RSV_HI; i++)
                    used_map[i] = 1'b1;
                next_page = 14'(kp);
            end
            MODE_ALLOC: begin
                // next fit: pointer to top, then page 1 up to the pointer
                for (int i = next_page; i < usable_pages && !hit; i++) begin
                    if (!used_map[i]) begin
                        pg  = i;
                        hit = 1'b1;
                    end
                end
                for (int i = 1; i < next_page && !hit; i++) begin
                    if (!used_map[i]) begin
                        pg  = i;
                        hit = 1'b1;
                    end
                end
                if (hit) begin
                    used_map[pg] = 1'b1;
                    next_page    = 14'(pg + 1);
                    g.page_addr  = ADDR_W'(pg * PAGE_BYTES_DEF);
                end else begin
                    g.status = ST_OOM;
                end
            end
            MODE_FREE: begin
                pg = fa / PAGE_BYTES_DEF;
                if (pg < usable_pages) begin
                    used_map[pg] = 1'b0;
                    if (pg < next_page)
                        next_page = 14'(pg);
                end else begin
                    g.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        return g;
    endfunction

    // Send one request; valid stays high on return so the next one can follow
    task automatic send_req(input mode_t md, input logic [31:0] fa, input bit fixed,
                            input grant_t given);
        grant_t g;
        cfg_valid <= 1'b0;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= fa;
        do @(posedge aclk); while (!s_tready);
        g = compute_grant(md, fa);
        if (md == MODE_ALLOC && g.status == ST_OK) begin
            n_granted++;
            alloc_pages.push_back(g.page_addr);
        end
        grant_q.push_back(fixed ? given : g);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_MEM_SIZE)
            mem_size_q = val;
        else
            kern_end_q = val;
    endtask

    // Stop driving and wait until every grant is back
    task automatic settle();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (grant_q.size() != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Grant checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (grant_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected grant: expected none, got addr %h status %0d",
                         $time, m_tdata, m_tuser);
            end else begin
                want = grant_q.pop_front();
                if (m_tdata !== OUT_TDATA_W'(want.page_addr)) begin
                    errors++;
                    $display("%0t: page_address mismatch: expected %h, got %h",
                             $time, OUT_TDATA_W'(want.page_addr), m_tdata);
                end
                if (m_tuser !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, m_tuser);
                end
                if (want.status == ST_OOM)
                    n_oom++;
                if (want.status == ST_RANGE)
                    n_range++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int unsigned n_req;
        int unsigned pick;
        int unsigned n_rand;
        int unsigned n_phase;
        logic [31:0] fa;
        logic [31:0] mem_v;
        logic [31:0] kern_v;
        mode_t       md;
        n_rand  = 0;
        n_phase = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].is_cfg) begin
                settle();
                write_reg(dir_tab[r].reg_idx, dir_tab[r].data);
            end else begin
                send_req(dir_tab[r].mode, dir_tab[r].data, dir_tab[r].fixed, dir_tab[r].grant);
            end
        end

        // random phases: new memory layout, init, then a mix of allocs and frees
        while (n_rand < RAND_ITEMS) begin
            idle_on = (n_rand < RAND_ITEMS - 90) && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                mem_v  = $urandom;
                kern_v = $urandom_range(0, 32'h0020_0000);
            end else if (pick == 1) begin
                mem_v  = 32'hFFFF_FFFF - $urandom_range(0, 32'hFFFF);
                kern_v = $urandom;
            end else begin
                // small memory so the map fills and the search wraps
                mem_v  = ($urandom_range(32'h80, 32'h160) << 12) | $urandom_range(0, 4095);
                kern_v = $urandom_range(0, 32'h0015_0000);
            end
            settle();
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_MEM_SIZE, mem_v);
                write_reg(REG_KERN_END, kern_v);
            end else begin
                write_reg(REG_KERN_END, kern_v);
                write_reg(REG_MEM_SIZE, mem_v);
            end
            alloc_pages.delete();
            send_req(MODE_INIT, $urandom, PRED, '0);
            n_rand++;
            n_phase++;

            n_req = $urandom_range(30, 60);
            for (int k = 0; k < n_req && n_rand < RAND_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                fa   = $urandom;
                if (pick < 55) begin
                    md = MODE_ALLOC;
                end else if (pick < 88) begin
                    md = MODE_FREE;
                    if (alloc_pages.size() != 0 && $urandom_range(0, 1) == 1)
                        fa = 32'(alloc_pages[$urandom_range(0, alloc_pages.size() - 1)]);
                    else
                        fa = 32'($urandom_range(0, int'(usable_pages) + 3)) << 12;
                    fa = fa | $urandom_range(0, PAGE_BYTES_DEF - 1);
                end else if (pick < 94) begin
                    md = MODE_NOP;
                end else if (pick < 97) begin
                    md = MODE_INIT;
                end else begin
                    md = MODE_FREE;   // wide random address, mostly out of range
                end
                send_req(md, fa, PRED, '0);
                n_rand++;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d directed rows and %0d random requests over %0d memory layouts",
                 DIR_ROWS, n_rand, n_phase);
        $display("grants: %0d pages handed out, %0d out of memory, %0d frees out of range",
                 n_granted, n_oom, n_range);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
